### hw/rtl/saio_pkg.sv
// Shared types and constants for the sample auxiliary information offsets box parser.
package saio_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_AUX_TYPE  = 3'd1,
    KIND_AUX_PARAM = 3'd2,
    KIND_COUNT     = 3'd3,
    KIND_OFFSET    = 3'd4,
    KIND_DONE      = 3'd5,
    KIND_TRUNCATED = 3'd6
  } kind_t;

  localparam logic [23:0] AuxPresentMask = 24'h000001;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [31:0] index;
    logic [31:0] used;
    logic        finished;
  } result_t;

endpackage

### hw/rtl/saio_parser_core.sv
// Parse state registers and the per-byte field assembly and phase logic.
module saio_parser_core import saio_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        end_of_box,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_AUX_TYPE  = 6'b000010,
    PH_AUX_PARAM = 6'b000100,
    PH_COUNT     = 6'b001000,
    PH_OFFSETS   = 6'b010000,
    PH_TRAILING  = 6'b100000
  } phase_t;

  localparam logic [32:0] CountMax = (33'd1 << COUNT_BITS) - 33'd1;

  phase_t                phase, phase_next;
  logic [2:0]            byte_count, byte_count_next;
  logic [63:0]           accum, accum_next;
  logic [7:0]            version, version_next;
  logic [COUNT_BITS-1:0] entries_total, entries_total_next;
  logic [COUNT_BITS-1:0] entries_seen, entries_seen_next;
  logic [31:0]           consumed, consumed_next;

  logic [63:0]           accum_shift;
  logic [31:0]           consumed_inc;
  logic [2:0]            last_byte;
  logic [31:0]           count_field;
  logic [COUNT_BITS-1:0] count_sat;
  logic [COUNT_BITS-1:0] seen_inc;
  phase_t                field_phase;
  kind_t                 field_kind;
  logic [31:0]           field_index;

  always_comb begin
    accum_shift  = {accum[55:0], data_byte};
    consumed_inc = (consumed == 32'hFFFF_FFFF) ? consumed : consumed + 32'd1;
    last_byte    = (phase == PH_OFFSETS && version != 8'd0) ? 3'd7 : 3'd3;
    count_field  = accum_shift[31:0];
    count_sat    = ({1'b0, count_field} > CountMax) ? CountMax[COUNT_BITS-1:0]
                                                    : count_field[COUNT_BITS-1:0];
    seen_inc     = entries_seen + {{(COUNT_BITS-1){1'b0}}, 1'b1};

    phase_next         = phase;
    byte_count_next    = byte_count;
    accum_next         = accum;
    version_next       = version;
    entries_total_next = entries_total;
    entries_seen_next  = entries_seen;
    consumed_next      = consumed;
    field_phase        = phase;
    field_kind         = KIND_HEADER;
    field_index        = 32'd0;
    res_valid          = 1'b0;
    res                = '0;

    if (phase == PH_TRAILING) begin
      if (end_of_box) begin
        res_valid    = 1'b1;
        res.kind     = KIND_DONE;
        res.used     = consumed;
        res.finished = 1'b1;
      end
    end else if (byte_count != last_byte) begin
      byte_count_next = byte_count + 3'd1;
      accum_next      = accum_shift;
      consumed_next   = consumed_inc;
      if (end_of_box) begin
        res_valid    = 1'b1;
        res.kind     = KIND_TRUNCATED;
        res.used     = consumed_inc;
        res.finished = 1'b1;
      end
    end else begin
      byte_count_next = 3'd0;
      accum_next      = 64'd0;
      consumed_next   = consumed_inc;
      unique case (phase)
        PH_HEADER: begin
          version_next = accum_shift[31:24];
          field_kind   = KIND_HEADER;
          field_phase  = ((accum_shift[23:0] & AuxPresentMask) != 24'd0) ? PH_AUX_TYPE
                                                                         : PH_COUNT;
        end
        PH_AUX_TYPE: begin
          field_kind  = KIND_AUX_TYPE;
          field_phase = PH_AUX_PARAM;
        end
        PH_AUX_PARAM: begin
          field_kind  = KIND_AUX_PARAM;
          field_phase = PH_COUNT;
        end
        PH_COUNT: begin
          entries_total_next = count_sat;
          entries_seen_next  = '0;
          field_kind         = KIND_COUNT;
          field_phase        = (count_sat == '0) ? PH_TRAILING : PH_OFFSETS;
        end
        PH_OFFSETS: begin
          field_kind        = KIND_OFFSET;
          field_index       = 32'(entries_seen);
          entries_seen_next = seen_inc;
          field_phase       = (seen_inc >= entries_total || seen_inc == '0) ? PH_TRAILING
                                                                             : PH_OFFSETS;
        end
        default: begin
          field_phase = PH_HEADER;
        end
      endcase
      phase_next = field_phase;
      res_valid  = 1'b1;
      if (end_of_box && field_phase != PH_TRAILING) begin
        res.kind     = KIND_TRUNCATED;
        res.used     = consumed_inc;
        res.finished = 1'b1;
      end else begin
        res.kind     = field_kind;
        res.value    = accum_shift;
        res.index    = field_index;
        res.used     = end_of_box ? consumed_inc : 32'd0;
        res.finished = end_of_box;
      end
    end

    // The final byte of a box always returns the parser to its start state.
    if (end_of_box) begin
      phase_next         = PH_HEADER;
      byte_count_next    = 3'd0;
      accum_next         = 64'd0;
      version_next       = 8'd0;
      entries_total_next = '0;
      entries_seen_next  = '0;
      consumed_next      = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_count    <= 3'd0;
      accum         <= 64'd0;
      version       <= 8'd0;
      entries_total <= '0;
      entries_seen  <= '0;
      consumed      <= 32'd0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      accum         <= accum_next;
      version       <= version_next;
      entries_total <= entries_total_next;
      entries_seen  <= entries_seen_next;
      consumed      <= consumed_next;
    end
  end

endmodule

### hw/rtl/saio_result_reg.sv
// Output register that holds one result transaction until the receiver takes it.
module saio_result_reg import saio_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

### hw/rtl/saio_box_stream_parser.sv
// Top level of the streaming parser for sample auxiliary information offsets box payloads.
//
// The input channel carries one payload byte per transaction, with end_of_box set
// on the final byte of a box. The output channel carries at most one result per
// input byte: header, aux type, aux parameter, entry count, each offset, and a
// done or truncated record; the record for the final byte of a box has box_finished set.
// A result appears on the output in the cycle after the byte that completes it is
// accepted. Throughput: one byte per cycle when not stalled, set by the single parse
// stage that updates the field state and writes the output register in the same cycle.
// A new byte is accepted whenever the output register is empty or is being taken,
// so a stalled receiver holds the result and stalls the input side in turn.
// Reset returns the parser to the header phase and empties the output register.
// COUNT_BITS sets the width of the entry counters; larger counts saturate.
module saio_box_stream_parser import saio_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_box,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  record_kind,
  output logic [63:0] field_value,
  output logic [31:0] entry_index,
  output logic [31:0] bytes_used,
  output logic        box_finished
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  saio_parser_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .end_of_box(end_of_box),
    .res_valid (res_valid),
    .res       (res)
  );

  saio_result_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept & res_valid),
    .load_data(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign record_kind  = out_data.kind;
  assign field_value  = out_data.value;
  assign entry_index  = out_data.index;
  assign bytes_used   = out_data.used;
  assign box_finished = out_data.finished;

endmodule
